@@ hdl/hcbp_pkg.sv @@
// Shared types and constants for the Huffman code bit packer.
// No dependencies; imported by every module of the block.
package hcbp_pkg;

    // Item kinds carried on s_tuser
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ENCODE = 2'd1;
    localparam logic [1:0] MODE_FLUSH  = 2'd2;

    localparam int BYTE_BITS = 8;
    localparam int CODE_W    = 16;
    localparam int LEN_W     = 5;
    localparam int PEND_W    = 7;
    localparam int CNT_W     = 3;
    localparam int VB_W      = 4;
    // pending bits plus the longest code
    localparam int ACC_W     = PEND_W + CODE_W;

    // Item held in the lookup stage, ready for packing
    typedef struct packed {
        logic              valid;
        logic              is_flush;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } stage_t;

    // One result transfer
    typedef struct packed {
        logic [BYTE_BITS-1:0] out_byte;
        logic [VB_W-1:0]      valid_bits;
        logic                 last;
    } result_t;

endpackage

@@ hdl/hcbp_table.sv @@
// Code and length tables plus the lookup stage register.
// Depends on hcbp_pkg.
module hcbp_table #(
    parameter int NUM_SYMBOLS  = 256,
    parameter int MAX_CODE_LEN = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_accept,
    input  logic [1:0]                  mode,
    input  logic [7:0]                  symbol,
    input  logic [hcbp_pkg::CODE_W-1:0] code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]  code_len,
    input  logic                        stage_take,
    output hcbp_pkg::stage_t            stage
);
    import hcbp_pkg::*;

    localparam int SYM_W     = $clog2(NUM_SYMBOLS);
    localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    logic [CODE_W-1:0] code_mem [NUM_SYMBOLS];
    logic [LEN_W-1:0]  len_mem  [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] written_reg;

    logic [SYM_W-1:0]  idx;
    logic              in_range;
    logic              do_load;
    logic [LEN_W-1:0]  sat_len;
    logic [CODE_W-1:0] code_mask;

    logic [CODE_W-1:0] code_rd_reg;
    logic [LEN_W-1:0]  len_rd_reg;
    logic              hit_reg;
    logic              valid_reg, valid_next;
    logic              flush_reg;

    assign idx      = symbol[SYM_W-1:0];
    assign in_range = ({1'b0, symbol} < 9'(NUM_SYMBOLS));
    assign do_load  = in_accept && (mode == MODE_LOAD) && in_range;

    // Saturate the length and drop code bits above it
    assign sat_len   = (code_len > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : code_len;
    assign code_mask = CODE_W'((17'd1 << sat_len) - 17'd1);

    // Table write and registered read
    always_ff @(posedge aclk) begin
        if (do_load) begin
            code_mem[idx] <= code_bits & code_mask;
            len_mem[idx]  <= sat_len;
        end
        if (in_accept) begin
            code_rd_reg <= code_mem[idx];
            len_rd_reg  <= len_mem[idx];
        end
    end

    // Per-entry written flags: an unwritten entry has length zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (do_load) begin
            written_reg[idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            hit_reg   <= in_range && written_reg[idx];
            flush_reg <= (mode == MODE_FLUSH);
        end
    end

    // Stage occupancy: encode and flush items enter, others are done at the table
    always_comb begin
        valid_next = valid_reg;
        if (stage_take) begin
            valid_next = 1'b0;
        end
        if (in_accept && (mode == MODE_ENCODE || mode == MODE_FLUSH)) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // A missing or unwritten entry contributes no length and no code bits
    assign stage.valid    = valid_reg;
    assign stage.is_flush = flush_reg;
    assign stage.len      = hit_reg ? len_rd_reg : '0;
    assign stage.code     = hit_reg ? code_rd_reg : '0;

endmodule

@@ hdl/hcbp_pack.sv @@
// Bit packer: pending-bit state and byte extraction for one item.
// Depends on hcbp_pkg.
module hcbp_pack (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  hcbp_pkg::stage_t       stage,
    input  logic                   fire,
    output logic [1:0]             res_count,
    output hcbp_pkg::result_t      res0,
    output hcbp_pkg::result_t      res1
);
    import hcbp_pkg::*;

    logic [PEND_W-1:0] pend_bits_reg, pend_bits_next;
    logic [CNT_W-1:0]  pend_cnt_reg, pend_cnt_next;

    logic [ACC_W-1:0]     acc;
    logic [LEN_W-1:0]     total;
    logic [LEN_W-1:0]     sh0, sh1;
    logic [BYTE_BITS-1:0] enc_byte0, enc_byte1;
    logic [1:0]           enc_count;
    logic [CNT_W-1:0]     rem;
    logic [BYTE_BITS-1:0] rem_mask;
    logic [VB_W-1:0]      flush_shift;
    logic [BYTE_BITS-1:0] flush_byte;

    // Append the code below the pending bits
    assign acc   = (ACC_W'(pend_bits_reg) << stage.len) | ACC_W'(stage.code);
    assign total = LEN_W'(pend_cnt_reg) + stage.len;
    assign sh0   = total - LEN_W'(BYTE_BITS);
    assign sh1   = total - LEN_W'(2 * BYTE_BITS);
    assign enc_byte0 = BYTE_BITS'(acc >> sh0);
    assign enc_byte1 = BYTE_BITS'(acc >> sh1);
    // total stays below 24, so bit 4 means two bytes and bit 3 one
    assign enc_count = total[4] ? 2'd2 : (total[3] ? 2'd1 : 2'd0);
    assign rem       = total[CNT_W-1:0];
    assign rem_mask  = (8'd1 << rem) - 8'd1;

    // Flush: left-justify the pending bits
    assign flush_shift = VB_W'(BYTE_BITS) - VB_W'(pend_cnt_reg);
    assign flush_byte  = (pend_cnt_reg == '0) ? '0
                         : (BYTE_BITS'(pend_bits_reg) << flush_shift);

    // Results of the item in the stage
    always_comb begin
        res0 = '0;
        res1 = '0;
        if (stage.is_flush) begin
            res_count       = 2'd1;
            res0.out_byte   = flush_byte;
            res0.valid_bits = VB_W'(pend_cnt_reg);
            res0.last       = 1'b1;
        end else begin
            res_count       = enc_count;
            res0.out_byte   = (enc_count == 2'd2) ? BYTE_BITS'(acc >> sh0) : enc_byte0;
            res0.valid_bits = VB_W'(BYTE_BITS);
            res1.out_byte   = enc_byte1;
            res1.valid_bits = VB_W'(BYTE_BITS);
        end
    end

    // Pending state update
    always_comb begin
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        if (fire) begin
            if (stage.is_flush) begin
                pend_bits_next = '0;
                pend_cnt_next  = '0;
            end else begin
                pend_bits_next = acc[PEND_W-1:0] & rem_mask[PEND_W-1:0];
                pend_cnt_next  = rem;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end else begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

    // Flush always leaves the packer empty
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && stage.is_flush |=> pend_cnt_reg == '0 && pend_bits_reg == '0)
        else $error("pending bits survive a flush");

    // Pending bits never exceed their count
    a_pend_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (PEND_W'(pend_bits_reg >> pend_cnt_reg)) == '0)
        else $error("pending bits above pending count");

endmodule

@@ hdl/hcbp_outq.sv @@
// Two-entry result queue driving the master side.
// Depends on hcbp_pkg.
module hcbp_outq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        push_count,
    input  hcbp_pkg::result_t push0,
    input  hcbp_pkg::result_t push1,
    input  logic              pop,
    output logic [1:0]        occupancy,
    output hcbp_pkg::result_t head
);
    import hcbp_pkg::*;

    result_t   q0_reg, q0_next;
    result_t   q1_reg, q1_next;
    logic [1:0] occ_reg, occ_next;
    logic [1:0] occ_left;

    // Shift out the popped entry, then append new results behind the rest
    always_comb begin
        occ_left = occ_reg - {1'b0, pop};
        q0_next  = pop ? q1_reg : q0_reg;
        q1_next  = q1_reg;
        if (push_count != 2'd0) begin
            if (occ_left == 2'd0) begin
                q0_next = push0;
                q1_next = push1;
            end else begin
                q1_next = push0;
            end
        end
        occ_next = occ_left + push_count;
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    assign occupancy = occ_reg;
    assign head      = q0_reg;

endmodule

@@ hdl/huffman_code_bit_packer.sv @@
// Huffman code bit packer: streaming wrapper around the table, packer and result queue.
// Depends on hcbp_pkg, hcbp_table, hcbp_pack and hcbp_outq.
//
// Usage:
//   Input transfers on s_* carry one item each; s_tuser selects the kind:
//   load a table entry, encode a symbol, or flush the end of a message.
//   Loads write the code table and give no result. An encode appends the
//   symbol's code and emits every byte it completes (0, 1 or 2 results).
//   A flush gives exactly one result with m_tlast high holding the pending
//   bits, zero-padded at the low end, with their count in valid_bits.
//   Each item is registered in the lookup stage, and its results are
//   registered in the output queue before they appear on m_*.
//   Throughput: one item per cycle while the output queue has room; an
//   encode that completes two bytes needs two transfers on the single-byte
//   result port, so a run of such items stalls s_tready.
//   Reset clears all table lengths (flags per entry), the pending bits
//   and the result queue; the block is ready right after reset.
//   When the receiver stalls, up to two results wait in the output queue,
//   one more item waits in the lookup stage, and s_tready then drops.
module huffman_code_bit_packer #(
    parameter int NUM_SYMBOLS  = 256,
    parameter int MAX_CODE_LEN = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // symbol[7:0], code_bits[23:8], code_len[28:24]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_byte[7:0], valid_bits[11:8]
    output logic        m_tlast
);
    import hcbp_pkg::*;

    logic       in_accept;
    logic       pop;
    logic       fire;
    logic [1:0] occupancy;
    logic [2:0] free_slots;
    logic [1:0] res_count;
    stage_t     stage;
    result_t    res0, res1, head;
    logic [1:0] push_count;

    assign in_accept = s_tvalid && s_tready;
    assign pop       = m_tvalid && m_tready;

    // An item leaves the stage once the queue has room for all its results
    assign free_slots = 3'd2 - {1'b0, occupancy} + {2'b0, pop};
    assign fire       = stage.valid && ({1'b0, res_count} <= free_slots);
    assign push_count = fire ? res_count : 2'd0;
    assign s_tready   = !stage.valid || fire;

    hcbp_table #(
        .NUM_SYMBOLS (NUM_SYMBOLS),
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .mode      (s_tuser),
        .symbol    (s_tdata[7:0]),
        .code_bits (s_tdata[23:8]),
        .code_len  (s_tdata[28:24]),
        .stage_take(fire),
        .stage     (stage)
    );

    hcbp_pack u_pack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .stage    (stage),
        .fire     (fire),
        .res_count(res_count),
        .res0     (res0),
        .res1     (res1)
    );

    hcbp_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_count(push_count),
        .push0     (res0),
        .push1     (res1),
        .pop       (pop),
        .occupancy (occupancy),
        .head      (head)
    );

    // Master side
    assign m_tvalid = (occupancy != 2'd0);
    assign m_tdata  = {4'b0, head.valid_bits, head.out_byte};
    assign m_tlast  = head.last;

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occupancy <= 2'd2)
        else $error("result queue overflow");

    a_stage_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && (s_tuser == MODE_ENCODE || s_tuser == MODE_FLUSH) |=> stage.valid)
        else $error("accepted item missing from lookup stage");

    a_valid_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast ? (head.valid_bits <= 4'd7) : (head.valid_bits == 4'd8)))
        else $error("bad valid_bits on result");

endmodule
